@@ hw/rtl/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared widths, constants and types of the round-robin task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

   localparam int unsigned ID_W          = 4;
   localparam int unsigned NUM_IDS       = 16;
   localparam int unsigned BURST_W       = 16;
   localparam int unsigned TICK_W        = 16;
   localparam int unsigned QUANT_W       = 8;
   localparam int unsigned SLICE_W       = 8;
   localparam int unsigned MAX_TASKS_DEF = 16;
   localparam int unsigned REQ_W         = 24;
   localparam int unsigned RSP_W         = 32;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;
   localparam logic [SLICE_W-1:0] SLICE_MAX     = 8'd255;

   typedef logic [ID_W-1:0]    task_id_type;
   typedef logic [BURST_W-1:0] work_type;

   // control from the scheduler to the ready queue
   typedef struct packed {
      logic        arr_push;
      task_id_type arr_id;
      logic        pre_push;
      task_id_type pre_id;
      logic        pop;
   } fifo_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/round_robin_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Round-robin scheduler: one tick per transaction, optional task arrival,
// reports the served task, completions, idle and dropped arrivals.
// ----------------------------------------------------------------------------
//   channel  dir  signals                          content
//   req      in   req_tvalid/tready/tdata[23:0]    one tick, optional arrival
//   rsp      out  rsp_tvalid/tready/tdata[31:0]    per-tick scheduling report
//   csr      in   csr_wr_en/csr_wr_data[7:0]       quantum
//
// One transaction per cycle while rsp is not stalled; the whole tick is
// evaluated in the cycle of acceptance and lands in the rsp output register.
// req_tready is high while the output register is empty or being drained,
// so a stall on rsp holds off req only while a report is still waiting.
// Reset (synchronous) empties the ready queue, stops the running task,
// zeroes the tick counter and sets the quantum to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler_unit #(
   parameter  int unsigned MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
   localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // arrival_valid, arrival_id[3:0], arrival_burst[15:0], zero pad
   input  wire logic [rrts_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // running_valid, running_id[3:0], dispatched, finished_valid,
   // finished_id[3:0], finish_tick[15:0], idle, arrival_dropped, zero pad
   output logic [rrts_pkg::RSP_W-1:0]     rsp_tdata,
   input  wire logic                      csr_wr_en,
   input  wire logic [rrts_pkg::QUANT_W-1:0] csr_wr_data
);
   import rrts_pkg::*;

   logic               req_fire;
   logic               a_valid;
   task_id_type        a_id;
   work_type           a_burst;

   logic [QUANT_W-1:0] quantum_ff;
   logic [QUANT_W-1:0] q_eff;
   logic [TICK_W-1:0]  tick_ff;
   logic               cur_valid_ff, cur_valid_in;
   task_id_type        cur_id_ff, cur_id_in;
   logic [SLICE_W-1:0] slice_ff, slice_in;
   work_type           cur_rem_ff, cur_rem_in;
   work_type           rem_ff [NUM_IDS];

   fifo_ctl_type       fifo_ctl;
   task_id_type        head_id;
   logic [CNT_W-1:0]   fifo_count;
   logic [CNT_W-1:0]   count_mid;
   logic               accept_arr;
   logic               dropped;
   logic               queue_busy;
   work_type           rem_cur_eff;
   logic               start;
   task_id_type        start_id;
   work_type           start_rem;
   logic               disp;
   logic               fin;
   logic               idle;
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   function automatic work_type sat_dec(input work_type w);
      return (w == '0) ? '0 : w - BURST_W'(1);
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign a_valid    = req_tdata[0];
   assign a_id       = req_tdata[4:1];
   assign a_burst    = req_tdata[20:5];
   assign q_eff      = (quantum_ff == '0) ? QUANT_W'(1) : quantum_ff;

   rrts_ready_fifo #(
      .MAX_TASKS (MAX_TASKS)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .head_id (head_id),
      .count   (fifo_count)
   );

   always_comb begin
      dropped     = a_valid && (fifo_count == CNT_W'(MAX_TASKS));
      accept_arr  = req_fire && a_valid && !dropped;
      count_mid   = fifo_count + CNT_W'(accept_arr);
      queue_busy  = (count_mid != '0);
      rem_cur_eff = (accept_arr && a_id == cur_id_ff) ? a_burst : cur_rem_ff;

      cur_valid_in = cur_valid_ff;
      cur_id_in    = cur_id_ff;
      slice_in     = slice_ff;
      cur_rem_in   = cur_rem_ff;
      start        = 1'b0;
      start_id     = head_id;
      disp         = 1'b0;
      fin          = 1'b0;
      fifo_ctl.arr_push = accept_arr;
      fifo_ctl.arr_id   = a_id;
      fifo_ctl.pre_push = 1'b0;
      fifo_ctl.pre_id   = cur_id_ff;
      fifo_ctl.pop      = 1'b0;

      if (!cur_valid_ff) begin
         start = queue_busy;
      end else if (rem_cur_eff == '0) begin
         fin          = 1'b1;
         cur_valid_in = 1'b0;
         cur_id_in    = '0;
         slice_in     = '0;
         start        = queue_busy;
      end else if (slice_ff >= q_eff) begin
         // preempt: requeue at the tail and start the head, or restart alone
         start             = 1'b1;
         fifo_ctl.pre_push = queue_busy;
         start_id          = queue_busy ? head_id : cur_id_ff;
      end else begin
         cur_rem_in = sat_dec(rem_cur_eff);
         slice_in   = (slice_ff < SLICE_MAX) ? slice_ff + SLICE_W'(1) : slice_ff;
      end

      fifo_ctl.pop = start && queue_busy;
      disp         = start;
      start_rem    = (accept_arr && start_id == a_id) ? a_burst : rem_ff[start_id];
      if (start) begin
         cur_valid_in = 1'b1;
         cur_id_in    = start_id;
         slice_in     = SLICE_W'(1);
         cur_rem_in   = sat_dec(start_rem);
      end

      if (!req_fire) begin
         fifo_ctl.pre_push = 1'b0;
         fifo_ctl.pop      = 1'b0;
      end

      idle = !cur_valid_in && ((count_mid - CNT_W'(fifo_ctl.pop)) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= QUANTUM_RESET;
         tick_ff      <= '0;
         cur_valid_ff <= 1'b0;
         cur_id_ff    <= '0;
         slice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            quantum_ff <= csr_wr_data;
         end
         if (req_fire) begin
            tick_ff      <= tick_ff + TICK_W'(1);
            cur_valid_ff <= cur_valid_in;
            cur_id_ff    <= cur_id_in;
            slice_ff     <= slice_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // remaining work per id; the served task's update wins over an arrival
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_rem_ff <= cur_rem_in;
         for (int i = 0; i < NUM_IDS; i++) begin
            if (cur_valid_in && cur_id_in == ID_W'(i)) begin
               rem_ff[i] <= cur_rem_in;
            end else if (accept_arr && a_id == ID_W'(i)) begin
               rem_ff[i] <= a_burst;
            end
         end
         rsp_data_ff <= {3'b000,
                         dropped,
                         idle,
                         fin ? tick_ff : TICK_W'(0),
                         fin ? cur_id_ff : ID_W'(0),
                         fin,
                         disp,
                         cur_valid_in ? cur_id_in : ID_W'(0),
                         cur_valid_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rrts_ready_fifo.sv @@
// ----------------------------------------------------------------------------
// rrts_ready_fifo
// Circular ready queue of task ids: an arrival push and a requeue push in
// the same cycle, one pop, with the head bypassed from an arrival into an
// empty queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ready_fifo #(
   parameter  int unsigned MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
   localparam int unsigned PTR_W     = $clog2(MAX_TASKS),
   localparam int unsigned CNT_W     = $clog2(MAX_TASKS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrts_pkg::fifo_ctl_type ctl,
   output rrts_pkg::task_id_type     head_id,
   output logic [CNT_W-1:0]          count
);
   import rrts_pkg::*;

   task_id_type      mem_ff [MAX_TASKS];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in, tail_mid;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(MAX_TASKS - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      // arrival lands first, the requeued task right behind it
      tail_mid = ctl.arr_push ? ptr_inc(tail_ff) : tail_ff;
      tail_in  = ctl.pre_push ? ptr_inc(tail_mid) : tail_mid;
      head_in  = ctl.pop ? ptr_inc(head_ff) : head_ff;
      count_in = count_ff + CNT_W'(ctl.arr_push) + CNT_W'(ctl.pre_push)
                 - CNT_W'(ctl.pop);
      head_id  = (count_ff == '0) ? ctl.arr_id : mem_ff[head_ff];
   end

   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.arr_push) begin
         mem_ff[tail_ff] <= ctl.arr_id;
      end
      if (ctl.pre_push) begin
         mem_ff[tail_mid] <= ctl.pre_id;
      end
   end

endmodule

`default_nettype wire
